>>> rtl/lla_pkg.sv
// ----------------------------------------------------------------------------
// Life-like automaton package
// Shared constants, operation and register codes, and beat types.
// ----------------------------------------------------------------------------
`default_nettype none

package lla_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    localparam logic STATUS_DONE    = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 7;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRAP_AROUND = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SURVIVE_MIN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SURVIVE_MAX = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BIRTH_COUNT = 3'd5;

    localparam logic [6:0] RST_GRID_WIDTH  = 7'd64;
    localparam logic [6:0] RST_GRID_HEIGHT = 7'd64;
    localparam logic       RST_WRAP_AROUND = 1'b1;
    localparam logic [3:0] RST_SURVIVE_MIN = 4'd2;
    localparam logic [3:0] RST_SURVIVE_MAX = 4'd3;
    localparam logic [3:0] RST_BIRTH_COUNT = 4'd3;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic       cell_value;
    } in_beat_t;

    typedef struct packed {
        logic read_value;
        logic status;
    } out_beat_t;

endpackage

`default_nettype wire

>>> rtl/life_like_automaton_generation.sv
// ----------------------------------------------------------------------------
// Life-like automaton generation engine
// Holds a binary cell grid and performs cell writes, cell reads and
// whole-grid generation steps under a small row-by-row sequencer.
// ----------------------------------------------------------------------------
// Usage: each input beat on s_* carries one operation and yields exactly one
// output beat on m_*. The block takes one operation at a time; s_ready is
// high only while the sequencer is idle. A read or write passes through the
// S_ACC_RD, S_ACC_DATA and S_RESP states to the output register, an invalid
// request goes straight to S_RESP, and the sequencer then returns to idle
// before the next beat can be taken. A generation step walks an active area
// of w columns by h rows with the single cell rule unit, which evaluates one
// cell per cycle from three buffered rows, plus a row read and write-back
// per row on the single memory port pair. Results wait in an output
// register; a stalled receiver holds the block only when a new result
// finds that register still full. After reset the grid memory is cleared
// one row per cycle, all MAX_HEIGHT rows, during which no operation is
// accepted. The user must make configuration writes only while no operation
// is in flight; the block does not enforce it. They apply to the next one.
// ----------------------------------------------------------------------------
`default_nettype none

module life_like_automaton_generation #(
    parameter int MAX_WIDTH  = lla_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lla_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire lla_pkg::in_beat_t                   s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output lla_pkg::out_beat_t                       m_data,
    input  wire logic                                cfg_wr_en,
    input  wire logic [lla_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [lla_pkg::CFG_DATA_W-1:0]      cfg_wr_data
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int WW  = XW + 1;
    localparam int HW  = YW + 1;
    localparam int CWW = (WW > 7) ? WW : 7;
    localparam int CWH = (HW > 7) ? HW : 7;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC_RD,
        S_ACC_DATA,
        S_ADV_LAST,
        S_ADV_FIRST,
        S_ADV_ROW0,
        S_ROW_FETCH,
        S_ROW_WAIT,
        S_CELL,
        S_ROW_WB,
        S_RESP
    } state_t;

    state_t state_reg;

    logic [6:0] grid_width_reg;
    logic [6:0] grid_height_reg;
    logic       wrap_around_reg;
    logic [3:0] survive_min_reg;
    logic [3:0] survive_max_reg;
    logic [3:0] birth_count_reg;

    logic [1:0]           op_reg;
    logic [XW-1:0]        col_reg;
    logic [YW-1:0]        row_reg;
    logic                 val_reg;
    logic                 res_value_reg;
    logic                 res_status_reg;
    logic                 m_valid_reg;
    lla_pkg::out_beat_t   m_data_reg;

    logic [MAX_WIDTH-1:0] up_reg;
    logic [MAX_WIDTH-1:0] mid_reg;
    logic [MAX_WIDTH-1:0] down_reg;
    logic [MAX_WIDTH-1:0] first_reg;
    logic [MAX_WIDTH-1:0] new_row_reg;

    logic [CWW-1:0]       w_full;
    logic [CWH-1:0]       h_full;
    logic [WW-1:0]        w_eff;
    logic [HW-1:0]        h_eff;
    logic [WW-1:0]        w_last;
    logic [HW-1:0]        h_last;
    logic                 out_of_grid;

    logic                 ram_we;
    logic [YW-1:0]        ram_waddr;
    logic [MAX_WIDTH-1:0] ram_wdata;
    logic [YW-1:0]        ram_raddr;
    logic [MAX_WIDTH-1:0] ram_rdata;
    logic [MAX_WIDTH-1:0] mod_row;

    logic [XW-1:0]        col_m;
    logic [XW-1:0]        col_p;
    logic                 left_ok;
    logic                 right_ok;
    logic [7:0]           nbits;
    logic [3:0]           ncount;
    logic                 new_bit;

    // Active area, saturated to the grid limits (a zero size counts as one).
    always_comb begin
        if (grid_width_reg == 7'd0) begin
            w_full = CWW'(1);
        end else if (CWW'(grid_width_reg) > CWW'(MAX_WIDTH)) begin
            w_full = CWW'(MAX_WIDTH);
        end else begin
            w_full = CWW'(grid_width_reg);
        end
        if (grid_height_reg == 7'd0) begin
            h_full = CWH'(1);
        end else if (CWH'(grid_height_reg) > CWH'(MAX_HEIGHT)) begin
            h_full = CWH'(MAX_HEIGHT);
        end else begin
            h_full = CWH'(grid_height_reg);
        end
    end

    assign w_eff  = w_full[WW-1:0];
    assign h_eff  = h_full[HW-1:0];
    assign w_last = w_eff - WW'(1);
    assign h_last = h_eff - HW'(1);

    assign out_of_grid = (CWW'(s_data.cell_x) >= w_full) || (CWH'(s_data.cell_y) >= h_full);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= lla_pkg::RST_GRID_WIDTH;
            grid_height_reg <= lla_pkg::RST_GRID_HEIGHT;
            wrap_around_reg <= lla_pkg::RST_WRAP_AROUND;
            survive_min_reg <= lla_pkg::RST_SURVIVE_MIN;
            survive_max_reg <= lla_pkg::RST_SURVIVE_MAX;
            birth_count_reg <= lla_pkg::RST_BIRTH_COUNT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lla_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_wr_data;
                lla_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_wr_data;
                lla_pkg::CFG_WRAP_AROUND: wrap_around_reg <= cfg_wr_data[0];
                lla_pkg::CFG_SURVIVE_MIN: survive_min_reg <= cfg_wr_data[3:0];
                lla_pkg::CFG_SURVIVE_MAX: survive_max_reg <= cfg_wr_data[3:0];
                lla_pkg::CFG_BIRTH_COUNT: birth_count_reg <= cfg_wr_data[3:0];
                default: ;
            endcase
        end
    end

    // Cell rule unit, one cell per cycle from the three buffered rows.
    assign col_m    = (col_reg == XW'(0)) ? w_last[XW-1:0] : col_reg - XW'(1);
    assign col_p    = (col_reg == w_last[XW-1:0]) ? XW'(0) : col_reg + XW'(1);
    assign left_ok  = wrap_around_reg || (col_reg != XW'(0));
    assign right_ok = wrap_around_reg || (col_reg != w_last[XW-1:0]);

    assign nbits = {
        up_reg[col_m] & left_ok,    up_reg[col_reg],   up_reg[col_p] & right_ok,
        mid_reg[col_m] & left_ok,                      mid_reg[col_p] & right_ok,
        down_reg[col_m] & left_ok,  down_reg[col_reg], down_reg[col_p] & right_ok
    };
    assign ncount = 4'($countones(nbits));

    always_comb begin
        if (mid_reg[col_reg]) begin
            new_bit = (ncount >= survive_min_reg) && (ncount <= survive_max_reg);
        end else begin
            new_bit = (ncount == birth_count_reg);
        end
    end

    always_comb begin
        mod_row          = ram_rdata;
        mod_row[col_reg] = val_reg;
        ram_we           = 1'b0;
        ram_waddr        = row_reg;
        ram_wdata        = new_row_reg;
        ram_raddr        = row_reg;
        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            S_ACC_DATA: begin
                ram_we    = (op_reg == lla_pkg::OP_WRITE);
                ram_wdata = mod_row;
            end
            S_ADV_LAST: begin
                ram_raddr = h_last[YW-1:0];
            end
            S_ADV_FIRST: begin
                ram_raddr = YW'(0);
            end
            S_ROW_FETCH: begin
                ram_raddr = row_reg + YW'(1);
            end
            S_ROW_WB: begin
                ram_we = 1'b1;
            end
            default: ;
        endcase
    end

    lla_row_ram #(
        .ROW_W (MAX_WIDTH),
        .ROWS  (MAX_HEIGHT)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            row_reg     <= YW'(0);
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_RESP)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    if (row_reg == YW'(MAX_HEIGHT - 1)) begin
                        row_reg   <= YW'(0);
                        state_reg <= S_IDLE;
                    end else begin
                        row_reg <= row_reg + YW'(1);
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg        <= s_data.operation;
                        col_reg       <= XW'(s_data.cell_x);
                        row_reg       <= YW'(s_data.cell_y);
                        val_reg       <= s_data.cell_value;
                        res_value_reg <= 1'b0;
                        unique case (s_data.operation) inside
                            lla_pkg::OP_WRITE, lla_pkg::OP_READ: begin
                                if (out_of_grid) begin
                                    res_status_reg <= lla_pkg::STATUS_IGNORED;
                                    state_reg      <= S_RESP;
                                end else begin
                                    res_status_reg <= lla_pkg::STATUS_DONE;
                                    state_reg      <= S_ACC_RD;
                                end
                            end
                            lla_pkg::OP_ADVANCE: begin
                                res_status_reg <= lla_pkg::STATUS_DONE;
                                state_reg      <= S_ADV_LAST;
                            end
                            default: begin
                                res_status_reg <= lla_pkg::STATUS_IGNORED;
                                state_reg      <= S_RESP;
                            end
                        endcase
                    end
                end
                S_ACC_RD: begin
                    state_reg <= S_ACC_DATA;
                end
                S_ACC_DATA: begin
                    if (op_reg == lla_pkg::OP_READ) begin
                        res_value_reg <= ram_rdata[col_reg];
                    end
                    state_reg <= S_RESP;
                end
                S_ADV_LAST: begin
                    state_reg <= S_ADV_FIRST;
                end
                S_ADV_FIRST: begin
                    up_reg    <= wrap_around_reg ? ram_rdata : '0;
                    state_reg <= S_ADV_ROW0;
                end
                S_ADV_ROW0: begin
                    mid_reg   <= ram_rdata;
                    first_reg <= ram_rdata;
                    row_reg   <= YW'(0);
                    state_reg <= S_ROW_FETCH;
                end
                S_ROW_FETCH: begin
                    new_row_reg <= mid_reg;
                    col_reg     <= XW'(0);
                    if (row_reg == h_last[YW-1:0]) begin
                        down_reg  <= wrap_around_reg ? first_reg : '0;
                        state_reg <= S_CELL;
                    end else begin
                        state_reg <= S_ROW_WAIT;
                    end
                end
                S_ROW_WAIT: begin
                    down_reg  <= ram_rdata;
                    state_reg <= S_CELL;
                end
                S_CELL: begin
                    new_row_reg[col_reg] <= new_bit;
                    col_reg              <= col_reg + XW'(1);
                    if (col_reg == w_last[XW-1:0]) begin
                        state_reg <= S_ROW_WB;
                    end
                end
                S_ROW_WB: begin
                    up_reg  <= mid_reg;
                    mid_reg <= down_reg;
                    if (row_reg == h_last[YW-1:0]) begin
                        state_reg <= S_RESP;
                    end else begin
                        row_reg   <= row_reg + YW'(1);
                        state_reg <= S_ROW_FETCH;
                    end
                end
                S_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.read_value <= res_value_reg;
                        m_data_reg.status     <= res_status_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_clear_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !s_ready)
        else $error("Operation accepted before the grid clear finished.");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("Grid memory written while the sequencer is idle.");

    a_row_in_area: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROW_FETCH || state_reg == S_ROW_WAIT ||
         state_reg == S_CELL || state_reg == S_ROW_WB) |-> ({1'b0, row_reg} < h_eff))
        else $error("Generation row outside the active area.");

    a_col_in_area: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CELL) |-> ({1'b0, col_reg} < w_eff))
        else $error("Generation column outside the active area.");
`endif

endmodule

`default_nettype wire

>>> rtl/lla_row_ram.sv
// ----------------------------------------------------------------------------
// Grid row memory
// One row of cells per word, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module lla_row_ram #(
    parameter int ROW_W = lla_pkg::DEF_MAX_WIDTH,
    parameter int ROWS  = lla_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                    aclk,
    input  wire logic                    wr_en,
    input  wire logic [$clog2(ROWS)-1:0] wr_addr,
    input  wire logic [ROW_W-1:0]        wr_data,
    input  wire logic [$clog2(ROWS)-1:0] rd_addr,
    output logic      [ROW_W-1:0]        rd_data
);

    logic [ROW_W-1:0] mem [ROWS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire
